/* rtl/core/mstxt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstxt_pkg
// Shared types and constants for the multi-screen text insert/delete core.
// ----------------------------------------------------------------------------
package mstxt_pkg;

    // Fixed field widths of the word on each channel
    localparam int OPCODE_W   = 2;
    localparam int SCREEN_W   = 3;
    localparam int POSITION_W = 12;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 13;
    localparam int CELL_DW    = 2 * BYTE_W;

    // Default sizing
    localparam int DEF_SCREENS  = 8;
    localparam int DEF_CAPACITY = 4096;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_REMOVE    = 2'd1,
        OP_READ_CELL = 2'd2,
        OP_READ_LEN  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SHIFT,
        ST_FINAL,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

endpackage : mstxt_pkg
`default_nettype wire

/* rtl/core/multi_screen_text_insert_delete_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_screen_text_insert_delete_core
// Per-screen text buffers of character/attribute cells with insert and remove
// by shifting the tail through a single-port-write, registered-read memory.
//
// Input channel (in_valid/in_ready) takes one command word: opcode, screen,
// position, char_code, attribute. Output channel (out_valid/out_ready) gives
// one result word per command: status, char_out, attr_out, length.
// After accept each command passes ST_CHECK and ends in ST_EMIT. A read of the
// length or any rejected command goes straight from ST_CHECK to ST_EMIT, a read
// of a cell waits in ST_RDWAIT, and an insert or remove copies n = length -
// position cells (at most CAPACITY) in ST_SHIFT, then writes in ST_FINAL.
// The shift moves one cell per cycle through the memory's one read and one
// write port. A new word can be taken from the cycle after the result enters
// the output register, so one command is in flight.
// A result waiting on a stalled receiver does not block the next command;
// only the following result waits for the output register to free up.
// Reset clears all screen lengths at once; cell contents need no clearing.
// ----------------------------------------------------------------------------
module multi_screen_text_insert_delete_core #(
    parameter int SCREENS  = mstxt_pkg::DEF_SCREENS,
    parameter int CAPACITY = mstxt_pkg::DEF_CAPACITY
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [mstxt_pkg::OPCODE_W-1:0]   opcode,
    input  wire logic [mstxt_pkg::SCREEN_W-1:0]   screen,
    input  wire logic [mstxt_pkg::POSITION_W-1:0] position,
    input  wire logic [mstxt_pkg::BYTE_W-1:0]     char_code,
    input  wire logic [mstxt_pkg::BYTE_W-1:0]     attribute,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [mstxt_pkg::STATUS_W-1:0]        status,
    output logic [mstxt_pkg::BYTE_W-1:0]          char_out,
    output logic [mstxt_pkg::BYTE_W-1:0]          attr_out,
    output logic [mstxt_pkg::LENGTH_W-1:0]        length
);

    localparam int SCR_W     = (SCREENS > 1) ? $clog2(SCREENS) : 1;
    localparam int SCR_EXT_W = (SCR_W > mstxt_pkg::SCREEN_W) ? SCR_W : mstxt_pkg::SCREEN_W;
    localparam int CELL_W    = $clog2(CAPACITY);
    localparam int LEN_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (LEN_W > mstxt_pkg::POSITION_W) ? LEN_W : mstxt_pkg::POSITION_W;
    localparam int ADDR_W    = SCR_W + CELL_W;
    localparam int MEM_DEPTH = SCREENS * (2 ** CELL_W);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    mstxt_pkg::state_t state_reg, state_next;

    mstxt_pkg::opcode_t             opcode_reg;
    logic [mstxt_pkg::SCREEN_W-1:0] screen_reg;
    logic [mstxt_pkg::POSITION_W-1:0] position_reg;
    logic [mstxt_pkg::BYTE_W-1:0]   char_reg;
    logic [mstxt_pkg::BYTE_W-1:0]   attr_reg;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CELL_W-1:0] pos_cell_reg, pos_cell_next;
    logic [CELL_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;

    // write-back stage of the copy loop
    logic              wb_valid_reg, wb_valid_next;
    logic [CELL_W-1:0] wb_addr_reg, wb_addr_next;

    // staged result
    mstxt_pkg::status_t            res_status_reg, res_status_next;
    logic [mstxt_pkg::BYTE_W-1:0]  res_char_reg, res_char_next;
    logic [mstxt_pkg::BYTE_W-1:0]  res_attr_reg, res_attr_next;
    logic [mstxt_pkg::LENGTH_W-1:0] res_len_reg, res_len_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    mstxt_pkg::status_t             out_status_reg;
    logic [mstxt_pkg::BYTE_W-1:0]   out_char_reg;
    logic [mstxt_pkg::BYTE_W-1:0]   out_attr_reg;
    logic [mstxt_pkg::LENGTH_W-1:0] out_len_reg;

    logic [LEN_W-1:0] screen_len_reg [SCREENS];

    // memory port controls
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [mstxt_pkg::CELL_DW-1:0] mem_wdata;
    logic [mstxt_pkg::CELL_DW-1:0] mem_q;

    logic len_we;
    logic load_out;
    logic in_fire;

    // ------------------------------------------------------------------------
    // Command decode against the addressed screen's length
    // ------------------------------------------------------------------------
    logic [SCR_EXT_W-1:0] screen_ext;
    logic [SCR_W-1:0]     scr_idx;
    logic                 scr_ok;
    logic [LEN_W-1:0]     len_cur;
    logic [LEN_W-1:0]     len_dec;
    logic [CMP_W-1:0]     pos_c;
    logic [CMP_W-1:0]     len_c;
    logic [CMP_W-1:0]     span_c;
    mstxt_pkg::status_t   chk_status;
    logic                 chk_shift;
    logic                 chk_read;
    logic                 is_insert;

    assign screen_ext = SCR_EXT_W'(screen_reg);
    assign scr_idx    = screen_ext[SCR_W-1:0];
    assign scr_ok     = (32'(screen_reg) < SCREENS);
    assign len_cur    = scr_ok ? screen_len_reg[scr_idx] : '0;
    assign len_dec    = len_cur - 1'b1;
    assign pos_c      = CMP_W'(position_reg);
    assign len_c      = CMP_W'(len_cur);
    assign span_c     = len_c - pos_c;
    assign is_insert  = (opcode_reg == mstxt_pkg::OP_INSERT);

    always_comb
    begin
        chk_status = mstxt_pkg::STAT_OK;
        chk_shift  = 1'b0;
        chk_read   = 1'b0;
        if (!scr_ok)
        begin
            chk_status = mstxt_pkg::STAT_RANGE;
        end
        else
        begin
            unique case (opcode_reg)
                mstxt_pkg::OP_INSERT:
                begin
                    // full is checked before the position
                    if (32'(len_cur) >= CAPACITY)
                        chk_status = mstxt_pkg::STAT_FULL;
                    else if (pos_c > len_c)
                        chk_status = mstxt_pkg::STAT_RANGE;
                    else
                        chk_shift = 1'b1;
                end
                mstxt_pkg::OP_REMOVE:
                begin
                    if (len_cur == '0)
                        chk_status = mstxt_pkg::STAT_EMPTY;
                    else if (pos_c >= len_c)
                        chk_status = mstxt_pkg::STAT_RANGE;
                    else
                        chk_shift = 1'b1;
                end
                mstxt_pkg::OP_READ_CELL:
                begin
                    if (pos_c >= len_c)
                        chk_status = mstxt_pkg::STAT_RANGE;
                    else
                        chk_read = 1'b1;
                end
                mstxt_pkg::OP_READ_LEN:
                begin
                    chk_status = mstxt_pkg::STAT_OK;
                end
                default:
                begin
                    chk_status = mstxt_pkg::STAT_OK;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    assign in_fire  = in_valid && in_ready;
    assign load_out = (state_reg == mstxt_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mstxt_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = mstxt_pkg::ST_CHECK;
            end
            mstxt_pkg::ST_CHECK:
            begin
                priority if (chk_shift)
                    state_next = mstxt_pkg::ST_SHIFT;
                else if (chk_read)
                    state_next = mstxt_pkg::ST_RDWAIT;
                else
                    state_next = mstxt_pkg::ST_EMIT;
            end
            mstxt_pkg::ST_SHIFT:
            begin
                if (remaining_reg == '0)
                    state_next = mstxt_pkg::ST_FINAL;
            end
            mstxt_pkg::ST_FINAL:  state_next = mstxt_pkg::ST_EMIT;
            mstxt_pkg::ST_RDWAIT: state_next = mstxt_pkg::ST_EMIT;
            mstxt_pkg::ST_EMIT:
            begin
                if (load_out)
                    state_next = mstxt_pkg::ST_IDLE;
            end
            default: state_next = mstxt_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs: memory port, copy loop and result staging
    // ------------------------------------------------------------------------
    always_comb
    begin
        len_next        = len_reg;
        pos_cell_next   = pos_cell_reg;
        rd_ptr_next     = rd_ptr_reg;
        remaining_next  = remaining_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = wb_addr_reg;
        res_status_next = res_status_reg;
        res_char_next   = res_char_reg;
        res_attr_next   = res_attr_reg;
        res_len_next    = res_len_reg;
        mem_re          = 1'b0;
        mem_raddr       = {scr_idx, rd_ptr_reg};
        len_we          = 1'b0;

        unique case (state_reg)
            mstxt_pkg::ST_CHECK:
            begin
                len_next        = len_cur;
                pos_cell_next   = pos_c[CELL_W-1:0];
                remaining_next  = span_c[LEN_W-1:0];
                // insert walks down from the last cell, remove walks up from position
                rd_ptr_next     = is_insert ? len_dec[CELL_W-1:0] : pos_c[CELL_W-1:0];
                res_status_next = chk_status;
                res_char_next   = '0;
                res_attr_next   = '0;
                res_len_next    = scr_ok ? mstxt_pkg::LENGTH_W'(len_cur) : '0;
                if (chk_read)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {scr_idx, pos_c[CELL_W-1:0]};
                end
            end
            mstxt_pkg::ST_SHIFT:
            begin
                if (remaining_reg != '0)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = {scr_idx, rd_ptr_reg};
                    // a remove reads its own position first only to keep the count
                    wb_valid_next  = is_insert || (rd_ptr_reg != pos_cell_reg);
                    wb_addr_next   = is_insert ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;
                    rd_ptr_next    = is_insert ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                end
            end
            mstxt_pkg::ST_FINAL:
            begin
                len_we          = 1'b1;
                len_next        = is_insert ? len_reg + 1'b1 : len_reg - 1'b1;
                res_status_next = mstxt_pkg::STAT_OK;
                res_len_next    = mstxt_pkg::LENGTH_W'(len_next);
            end
            mstxt_pkg::ST_RDWAIT:
            begin
                res_char_next = mem_q[mstxt_pkg::BYTE_W-1:0];
                res_attr_next = mem_q[mstxt_pkg::CELL_DW-1:mstxt_pkg::BYTE_W];
            end
            mstxt_pkg::ST_IDLE, mstxt_pkg::ST_EMIT:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Write port: copy-loop write-back, else the final cell of an insert/remove
    logic [LEN_W-1:0] len_last;
    assign len_last = len_reg - 1'b1;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {scr_idx, wb_addr_reg};
        mem_wdata = mem_q;
        if (wb_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == mstxt_pkg::ST_FINAL)
        begin
            mem_we = 1'b1;
            if (is_insert)
            begin
                mem_waddr = {scr_idx, pos_cell_reg};
                mem_wdata = {attr_reg, char_reg};
            end
            else
            begin
                // freed last cell keeps its attribute, character cleared
                mem_waddr = {scr_idx, len_last[CELL_W-1:0]};
                mem_wdata = {mem_q[mstxt_pkg::CELL_DW-1:mstxt_pkg::BYTE_W],
                             {mstxt_pkg::BYTE_W{1'b0}}};
            end
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign in_ready  = (state_reg == mstxt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign char_out  = out_char_reg;
    assign attr_out  = out_attr_reg;
    assign length    = out_len_reg;

    // ------------------------------------------------------------------------
    // Text store: one write and one registered read per cycle
    // ------------------------------------------------------------------------
    logic [mstxt_pkg::CELL_DW-1:0] text_mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            text_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= text_mem[mem_raddr];
    end

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstxt_pkg::ST_IDLE;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SCREENS; i++)
                screen_len_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
            if (len_we)
                screen_len_reg[scr_idx] <= len_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg   <= mstxt_pkg::opcode_t'(opcode);
            screen_reg   <= screen;
            position_reg <= position;
            char_reg     <= char_code;
            attr_reg     <= attribute;
        end
        len_reg        <= len_next;
        pos_cell_reg   <= pos_cell_next;
        rd_ptr_reg     <= rd_ptr_next;
        remaining_reg  <= remaining_next;
        wb_addr_reg    <= wb_addr_next;
        res_status_reg <= res_status_next;
        res_char_reg   <= res_char_next;
        res_attr_reg   <= res_attr_next;
        res_len_reg    <= res_len_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_char_reg   <= res_char_reg;
            out_attr_reg   <= res_attr_reg;
            out_len_reg    <= res_len_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == mstxt_pkg::ST_CHECK))
        else $error("accepted word did not enter decode");

    a_wb_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> (state_reg == mstxt_pkg::ST_SHIFT ||
                          state_reg == mstxt_pkg::ST_FINAL))
        else $error("copy write-back outside the shift loop");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstxt_pkg::ST_SHIFT && remaining_reg != '0)
        |=> (remaining_reg == LEN_W'($past(remaining_reg) - 1'b1)))
        else $error("shift counter did not step");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstxt_pkg::ST_FINAL && is_insert)
        |=> (screen_len_reg[scr_idx] == LEN_W'($past(len_reg) + 1'b1)))
        else $error("insert did not grow the screen length");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == mstxt_pkg::ST_EMIT))
        else $error("result presented outside emit");

endmodule : multi_screen_text_insert_delete_core
`default_nettype wire

/* test/text_edit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_edit_checker
// Watches both channels of the multi-screen text core. Every accepted
// command word is run through a local image of the screen buffers to give
// the expected result word. Each accepted result word is compared field by
// field against the oldest expectation. Mismatches and outstanding
// expectations are handed to the testbench top.
// ----------------------------------------------------------------------------
module text_edit_checker
    import mstxt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [OPCODE_W-1:0]   opcode,
    input  wire logic [SCREEN_W-1:0]   screen,
    input  wire logic [POSITION_W-1:0] position,
    input  wire logic [BYTE_W-1:0]     char_code,
    input  wire logic [BYTE_W-1:0]     attribute,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [STATUS_W-1:0]   status,
    input  wire logic [BYTE_W-1:0]     char_out,
    input  wire logic [BYTE_W-1:0]     attr_out,
    input  wire logic [LENGTH_W-1:0]   length,
    output int                         mismatch_count,
    output int                         outstanding
);

    localparam int SCREENS  = DEF_SCREENS;
    localparam int CAPACITY = DEF_CAPACITY;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   char_byte;
        logic [BYTE_W-1:0]   attr_byte;
        logic [LENGTH_W-1:0] len;
    } text_result_t;

    // Local image of the cell store and the per-screen lengths
    logic [CELL_DW-1:0] cell_image [SCREENS*CAPACITY];
    int unsigned        length_image [SCREENS];
    text_result_t       expected_words [$];

    initial
    begin
        foreach (length_image[s])
            length_image[s] = 0;
        foreach (cell_image[c])
            cell_image[c] = '0;
        mismatch_count = 0;
        outstanding    = 0;
    end

    // Apply one command to the image and return the result word it gives
    function automatic text_result_t predict_edit(input opcode_t op,
                                                  input int unsigned scr,
                                                  input int unsigned pos,
                                                  input logic [BYTE_W-1:0] ch,
                                                  input logic [BYTE_W-1:0] at);
        text_result_t r;
        int unsigned  base;
        int unsigned  n;
        int unsigned  i;
        r = '0;
        if (scr >= SCREENS)
        begin
            r.status = STAT_RANGE;
            return r;
        end
        base = scr * CAPACITY;
        n    = length_image[scr];
        r.status = STAT_OK;
        case (op)
            OP_INSERT:
            begin
                // full is checked before the position
                if (n >= CAPACITY)
                    r.status = STAT_FULL;
                else if (pos > n)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = n; i > pos; i--)
                        cell_image[base + i] = cell_image[base + i - 1];
                    cell_image[base + pos] = {at, ch};
                    n++;
                end
            end
            OP_REMOVE:
            begin
                // empty is checked before the position
                if (n == 0)
                    r.status = STAT_EMPTY;
                else if (pos >= n)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = pos; i + 1 < n; i++)
                        cell_image[base + i] = cell_image[base + i + 1];
                    // freed cell loses its character, keeps its attribute
                    cell_image[base + n - 1][BYTE_W-1:0] = '0;
                    n--;
                end
            end
            OP_READ_CELL:
            begin
                if (pos >= n)
                    r.status = STAT_RANGE;
                else
                begin
                    r.char_byte = cell_image[base + pos][BYTE_W-1:0];
                    r.attr_byte = cell_image[base + pos][CELL_DW-1:BYTE_W];
                end
            end
            default: ;
        endcase
        length_image[scr] = n;
        r.len = LENGTH_W'(n);
        return r;
    endfunction

    // Compare result words first, then take in the new command word
    always @(posedge clk)
    begin
        text_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word %0d/%h/%h/%0d, expected none",
                             $time, status, char_out, attr_out, length);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (status !== want.status || char_out !== want.char_byte ||
                        attr_out !== want.attr_byte || length !== want.len)
                    begin
                        $display("%0t: expected %0d/%h/%h/%0d, actual %0d/%h/%h/%0d",
                                 $time, want.status, want.char_byte, want.attr_byte,
                                 want.len, status, char_out, attr_out, length);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_edit(opcode_t'(opcode), 32'(screen),
                                                      32'(position), char_code,
                                                      attribute));
            outstanding <= expected_words.size();
        end
    end

endmodule : text_edit_checker

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-screen text insert/delete core. A short
// directed run covers the empty and range statuses, then random commands
// follow with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import mstxt_pkg::*;

    localparam int CAP     = DEF_CAPACITY;
    localparam int MAX_POS = (1 << POSITION_W) - 1;
    localparam int LAST_SCREEN = 7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [OPCODE_W-1:0]   opcode    = '0;
    logic [SCREEN_W-1:0]   screen    = '0;
    logic [POSITION_W-1:0] position  = '0;
    logic [BYTE_W-1:0]     char_code = '0;
    logic [BYTE_W-1:0]     attribute = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [STATUS_W-1:0]   status;
    logic [BYTE_W-1:0]     char_out;
    logic [BYTE_W-1:0]     attr_out;
    logic [LENGTH_W-1:0]   length;

    int fail_count;
    int pending;

    // Idling control: calm stops idling, hold_req asks for the long hold-off
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // Screen lengths as the stimulus expects them, to aim positions
    int unsigned lane_len [DEF_SCREENS];

    initial
    begin
        foreach (lane_len[s])
            lane_len[s] = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_screen_text_insert_delete_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .screen    (screen),
        .position  (position),
        .char_code (char_code),
        .attribute (attribute),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .char_out  (char_out),
        .attr_out  (attr_out),
        .length    (length)
    );

    text_edit_checker CHECK (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .screen         (screen),
        .position       (position),
        .char_code      (char_code),
        .attribute      (attribute),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .char_out       (char_out),
        .attr_out       (attr_out),
        .length         (length),
        .mismatch_count (fail_count),
        .outstanding    (pending)
    );

    // Receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Offer one command word and wait until it is taken
    task automatic send_command(input opcode_t op, input int unsigned scr,
                                input int unsigned pos, input int unsigned ch,
                                input int unsigned at);
        int unsigned gap;
        int unsigned n;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30)
            gap = $urandom_range(1, 4);
        // valid only drops when a gap is taken
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode    <= op;
        screen    <= SCREEN_W'(scr);
        position  <= POSITION_W'(pos);
        char_code <= BYTE_W'(ch);
        attribute <= BYTE_W'(at);
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = lane_len[scr];
        if (op == OP_INSERT && n < CAP && pos <= n)
            lane_len[scr] = n + 1;
        else if (op == OP_REMOVE && n > 0 && pos < n)
            lane_len[scr] = n - 1;
    endtask

    initial
    begin
        int unsigned k;
        int unsigned scr;
        int unsigned pos;
        int unsigned n;
        int unsigned pick;
        opcode_t     op;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corner statuses on an empty screen, then a few cells
        send_command(OP_READ_LEN,  0, 0, 0, 0);
        send_command(OP_REMOVE,    0, 0, 0, 0);        // empty
        send_command(OP_READ_CELL, 0, 0, 0, 0);        // read past end
        send_command(OP_INSERT,    0, 1, 'h11, 'h22);  // insert past end
        send_command(OP_INSERT,    0, 0, 'hFF, 'hFF);
        send_command(OP_INSERT,    0, 0, 'h00, 'h00);  // shifts the tail
        send_command(OP_INSERT,    0, 2, 'h5A, 'hA5);  // append
        send_command(OP_READ_CELL, 0, 0, 0, 0);
        send_command(OP_READ_CELL, 0, 1, 0, 0);
        send_command(OP_READ_CELL, 0, 2, 0, 0);
        send_command(OP_READ_CELL, 0, 3, 0, 0);
        send_command(OP_REMOVE,    0, 3, 0, 0);        // remove past end
        send_command(OP_REMOVE,    0, 1, 0, 0);
        send_command(OP_REMOVE,    0, MAX_POS, 0, 0);
        send_command(OP_INSERT,    0, MAX_POS, 'h01, 'h80);
        send_command(OP_READ_LEN,  0, MAX_POS, 'hFF, 'hFF);

        // Random: mostly in-range positions, some noise anywhere
        for (k = 0; k < 124; k++)
        begin
            if (k == 45)
                hold_req <= 1'b1;
            if (k == 80)
                calm <= 1'b1;
            if (k == 110)
                calm <= 1'b0;
            scr  = ($urandom_range(0, 99) < 15) ? LAST_SCREEN : $urandom_range(0, 6);
            pick = $urandom_range(0, 99);
            op   = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_REMOVE :
                   (pick < 90) ? OP_READ_CELL : OP_READ_LEN;
            n    = lane_len[scr];
            // short screens anywhere, long ones near the end to keep shifts short
            if ($urandom_range(0, 99) < 20)
                pos = $urandom_range(0, MAX_POS);
            else if (op == OP_INSERT)
                pos = (n < 64) ? $urandom_range(0, n) : n - $urandom_range(0, 8);
            else if (n == 0)
                pos = 0;
            else
                pos = (n < 64) ? $urandom_range(0, n - 1) : n - 1 - $urandom_range(0, 8);
            if (pos > MAX_POS)
                pos = MAX_POS;
            send_command(op, scr, pos, $urandom_range(0, 255), $urandom_range(0, 255));
        end
        in_valid <= 1'b0;

        // Drain: let the last expectation register, then wait for it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule : tb_top
